// ===== sv/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared constants, request and status codes, and the cell control type
// for the circular double-ended queue.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int DATA_W        = 32;
    localparam int MODE_W        = 3;
    localparam int STATUS_W      = 2;
    localparam int CAP_W         = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK_REAR  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_6    = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7    = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
    } cdq_cell_ctl_t;

endpackage

// ===== sv/cdq_cell.sv =====
// ----------------------------------------------------------------------------
// cdq_cell
// One cell of the queue chain. Holds the word at its place counted from the
// front and the word at its place counted from the rear, and shifts both
// against its neighbors.
// ----------------------------------------------------------------------------
module cdq_cell
    import cdq_pkg::*;
#(
    parameter int CNT_W = 6,
    parameter int INDEX = 0
) (
    input  logic                     aclk,
    input  cdq_cell_ctl_t            ctl,
    input  logic [CNT_W-1:0]         count,
    input  logic signed [DATA_W-1:0] word,
    input  logic signed [DATA_W-1:0] left_f,
    input  logic signed [DATA_W-1:0] left_r,
    input  logic signed [DATA_W-1:0] right_f,
    input  logic signed [DATA_W-1:0] right_r,
    output logic signed [DATA_W-1:0] f_out,
    output logic signed [DATA_W-1:0] r_out
);

    logic signed [DATA_W-1:0] f_reg;
    logic signed [DATA_W-1:0] f_next;
    logic signed [DATA_W-1:0] r_reg;
    logic signed [DATA_W-1:0] r_next;
    logic                     at_count;

    assign at_count = (count == CNT_W'(INDEX));

    always_comb begin
        f_next = f_reg;
        r_next = r_reg;
        if (ctl.push_front) begin
            f_next = left_f;
            if (at_count) begin
                r_next = word;
            end
        end
        if (ctl.push_rear) begin
            r_next = left_r;
            if (at_count) begin
                f_next = word;
            end
        end
        if (ctl.pop_front) begin
            f_next = right_f;
        end
        if (ctl.pop_rear) begin
            r_next = right_r;
        end
    end

    always_ff @(posedge aclk) begin
        f_reg <= f_next;
        r_reg <= r_next;
    end

    assign f_out = f_reg;
    assign r_out = r_reg;

endmodule

// ===== sv/circular_double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// circular_double_ended_queue_unit
// Double-ended queue of signed words with a run-time capacity limit.
// ----------------------------------------------------------------------------
// Takes one request word per clock and returns its result word in the next
// cycle through an output register; input ready follows the output side, so
// requests stream at one per cycle while results are taken. The queue is a
// chain of DEPTH cells with two lanes: one keeps the words in order from the
// front, the other in order from the rear, so both ends always sit in cell 0
// and every push or pop is a single shift of the chain. Writing the
// capacity empties the queue at once; there is no clearing pass after reset.
module circular_double_ended_queue_unit
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,   // capacity
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,       // push_data[31:0]
    input  logic [7:0]        s_tuser,       // mode[2:0], zeros
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,       // read_data[31:0]
    output logic [7:0]        m_tuser        // status[1:0], zeros
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0] m_status_reg;

    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  cap_eff;
    logic              accept;
    logic [MODE_W-1:0] mode;
    logic signed [DATA_W-1:0] word;
    logic              q_empty;
    logic              q_full;
    logic              is_push;
    logic              is_pop;
    logic              is_peek;
    logic              use_rear;
    logic              push_ok;
    logic              pop_ok;
    logic [DATA_W-1:0] res_data;
    logic [STATUS_W-1:0] res_status;
    cdq_cell_ctl_t     ctl;

    logic signed [DATA_W-1:0] f_lane [DEPTH];
    logic signed [DATA_W-1:0] r_lane [DEPTH];

    assign accept = s_tvalid && s_tready;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign mode = s_tuser[MODE_W-1:0];
    assign word = s_tdata;

    always_comb begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CMP_W'(DEPTH)) begin
            cap_eff = CMP_W'(DEPTH);
        end else begin
            cap_eff = cap_ext;
        end
    end

    assign q_empty  = (count_reg == '0);
    assign q_full   = (CMP_W'(count_reg) >= cap_eff);
    assign is_push  = (mode == MODE_PUSH_REAR) || (mode == MODE_PUSH_FRONT);
    assign is_pop   = (mode == MODE_POP_REAR) || (mode == MODE_POP_FRONT);
    assign is_peek  = (mode == MODE_PEEK_REAR) || (mode == MODE_PEEK_FRONT);
    assign use_rear = (mode == MODE_POP_REAR) || (mode == MODE_PEEK_REAR);
    assign push_ok  = is_push && !q_full;
    assign pop_ok   = is_pop && !q_empty;

    always_comb begin
        ctl.push_front = accept && push_ok && (mode == MODE_PUSH_FRONT);
        ctl.push_rear  = accept && push_ok && (mode == MODE_PUSH_REAR);
        ctl.pop_front  = accept && pop_ok && (mode == MODE_POP_FRONT);
        ctl.pop_rear   = accept && pop_ok && (mode == MODE_POP_REAR);
    end

    always_comb begin
        res_data   = '0;
        res_status = ST_OK;
        if (is_push && q_full) begin
            res_status = ST_FULL;
        end else if ((is_pop || is_peek) && q_empty) begin
            res_status = ST_EMPTY;
        end else if (is_pop || is_peek) begin
            res_data = use_rear ? r_lane[0] : f_lane[0];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cfg_wr_en) begin
            count_next = '0;
        end else if (accept && push_ok) begin
            count_next = count_reg + CNT_W'(1);
        end else if (accept && pop_ok) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= CAP_RESET;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            if (s_tready) begin
                m_tvalid_reg <= s_tvalid;
            end
        end
        if (accept) begin
            m_tdata_reg  <= res_data;
            m_status_reg <= res_status;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] lf;
        logic signed [DATA_W-1:0] lr;
        logic signed [DATA_W-1:0] rf;
        logic signed [DATA_W-1:0] rr;
        if (i == 0) begin : g_first
            assign lf = word;
            assign lr = word;
        end else begin : g_mid
            assign lf = f_lane[i-1];
            assign lr = r_lane[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign rf = f_lane[i];
            assign rr = r_lane[i];
        end else begin : g_inner
            assign rf = f_lane[i+1];
            assign rr = r_lane[i+1];
        end
        cdq_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .aclk    (aclk),
            .ctl     (ctl),
            .count   (count_reg),
            .word    (word),
            .left_f  (lf),
            .left_r  (lr),
            .right_f (rf),
            .right_r (rr),
            .f_out   (f_lane[i]),
            .r_out   (r_lane[i])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = {{(8-STATUS_W){1'b0}}, m_status_reg};

endmodule

// ===== sv/cdq_checker.sv =====
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module cdq_checker
    import cdq_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [7:0]        s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [31:0]       m_tdata,
    input logic [7:0]        m_tuser
);

    // no result word right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // refused requests return zero data
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser[STATUS_W-1:0] != ST_OK)) |-> (m_tdata == '0))
        else $error("nonzero data with error status");

    // unused request codes answer ok with zero data on the next cycle
    a_unused_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && ((s_tuser[MODE_W-1:0] == MODE_SPARE_6) ||
                                  (s_tuser[MODE_W-1:0] == MODE_SPARE_7)))
        |=> (m_tvalid && (m_tuser[STATUS_W-1:0] == ST_OK) && (m_tdata == '0)))
        else $error("unused request code gave wrong result");

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result word changed");

endmodule

bind circular_double_ended_queue_unit cdq_checker u_cdq_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circular double-ended queue unit.
// ----------------------------------------------------------------------------
// Streams push, pop and peek requests into the queue and keeps its own copy
// of the ring (slots, front and rear position, empty flag, capacity) to work
// out the word and status each request must return. Results are compared in
// order as they leave the block. Directed tests cover the empty and full
// answers, both ends, the spare modes, the wrap at the last slot and the
// capacity extremes; random phases then run with several capacities and
// with the sender idling, the receiver stalling, both, or neither, plus one
// long receiver hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
    import cdq_pkg::*;

    localparam int RING_SLOTS = 32;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic [STATUS_W-1:0] status;
    } dq_result_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [CAP_W-1:0]  cfg_wr_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;     // push_data[31:0]
    logic [7:0]        s_tuser;     // mode[2:0], zeros
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;     // read_data[31:0]
    logic [7:0]        m_tuser;     // status[1:0], zeros

    // queue model
    logic [DATA_W-1:0] ring_mem [RING_SLOTS];
    logic [4:0]        front_idx;
    logic [4:0]        rear_idx;
    logic              ring_empty;
    logic [CAP_W-1:0]  cap_reg;

    dq_result_t expected_results[$];

    int error_count;
    int words_in;
    int words_out;
    int full_seen;
    int empty_seen;
    int cap_writes;
    int gap_pct;
    int stall_pct;
    int hold_request;

    circular_double_ended_queue_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("%0t timeout, %0d results still pending", $realtime,
                 expected_results.size());
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [CAP_W-1:0] ring_size();
        if (cap_reg == '0)
            return 6'd1;
        if (cap_reg > 6'd32)
            return 6'd32;
        return cap_reg;
    endfunction

    function automatic logic [4:0] step_up(input logic [4:0] p);
        logic [CAP_W-1:0] n;
        n = {1'b0, p} + 6'd1;
        return (n >= ring_size()) ? 5'd0 : n[4:0];
    endfunction

    function automatic logic [4:0] step_down(input logic [4:0] p);
        logic [CAP_W-1:0] last;
        last = ring_size() - 6'd1;
        return (p == 5'd0) ? last[4:0] : p - 5'd1;
    endfunction

    function automatic void clear_ring();
        front_idx  = '0;
        rear_idx   = '0;
        ring_empty = 1'b1;
    endfunction

    function automatic dq_result_t apply_request(input logic [MODE_W-1:0] op,
                                                 input logic [DATA_W-1:0] word);
        dq_result_t r;
        r.read_data = '0;
        r.status    = ST_OK;
        case (op)
            MODE_PUSH_REAR, MODE_PUSH_FRONT: begin
                if (ring_empty) begin
                    front_idx   = '0;
                    rear_idx    = '0;
                    ring_empty  = 1'b0;
                    ring_mem[0] = word;
                end else if (step_up(rear_idx) == front_idx) begin
                    r.status = ST_FULL;
                end else if (op == MODE_PUSH_REAR) begin
                    rear_idx = step_up(rear_idx);
                    ring_mem[rear_idx] = word;
                end else begin
                    front_idx = step_down(front_idx);
                    ring_mem[front_idx] = word;
                end
            end
            MODE_POP_REAR, MODE_POP_FRONT: begin
                if (ring_empty) begin
                    r.status = ST_EMPTY;
                end else if (front_idx == rear_idx) begin
                    r.read_data = ring_mem[front_idx];
                    clear_ring();
                end else if (op == MODE_POP_REAR) begin
                    r.read_data = ring_mem[rear_idx];
                    rear_idx = step_down(rear_idx);
                end else begin
                    r.read_data = ring_mem[front_idx];
                    front_idx = step_up(front_idx);
                end
            end
            MODE_PEEK_REAR, MODE_PEEK_FRONT: begin
                if (ring_empty)
                    r.status = ST_EMPTY;
                else
                    r.read_data = (op == MODE_PEEK_REAR) ? ring_mem[rear_idx]
                                                         : ring_mem[front_idx];
            end
            default: ;
        endcase
        return r;
    endfunction

    // scoreboard: check leaving words, then predict entering ones
    always @(posedge aclk) begin
        dq_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                words_out++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t unexpected result: data %h status %0d", $realtime,
                             m_tdata, m_tuser);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.read_data) begin
                        error_count++;
                        $display("%0t read_data mismatch: expected %h actual %h",
                                 $realtime, want.read_data, m_tdata);
                    end
                    if (m_tuser !== {6'b0, want.status}) begin
                        error_count++;
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $realtime, want.status, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                words_in++;
                want = apply_request(s_tuser[MODE_W-1:0], s_tdata);
                if (want.status == ST_FULL)
                    full_seen++;
                if (want.status == ST_EMPTY)
                    empty_seen++;
                expected_results.push_back(want);
            end
        end
    end

    // result side ready, with random stalls and long hold-offs
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99, 0) >= stall_pct);
            end
        end
    end

    task automatic send_word(input logic [MODE_W-1:0] op, input logic [DATA_W-1:0] word);
        while (gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= {5'b0, op};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cap_reg = value;
        clear_ring();
        cap_writes++;
        @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(7, 0))
            0: return 32'h0000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_and_spare_modes();
        send_word(MODE_POP_REAR, 32'h1234_5678);
        send_word(MODE_POP_FRONT, 32'h0);
        send_word(MODE_PEEK_REAR, 32'hffff_ffff);
        send_word(MODE_PEEK_FRONT, 32'h0);
        send_word(MODE_SPARE_6, 32'hffff_ffff);
        send_word(MODE_SPARE_7, 32'h8000_0000);
        stop_sending();
    endtask

    task automatic test_both_ends();
        send_word(MODE_PUSH_REAR, 32'h7fff_ffff);
        send_word(MODE_PUSH_FRONT, 32'h8000_0000);
        send_word(MODE_PUSH_REAR, 32'hffff_ffff);
        send_word(MODE_PEEK_REAR, 32'h0);
        send_word(MODE_PEEK_FRONT, 32'h0);
        send_word(MODE_SPARE_7, 32'h5555_aaaa);
        send_word(MODE_POP_FRONT, 32'h0);
        send_word(MODE_POP_REAR, 32'h0);
        send_word(MODE_POP_REAR, 32'h0);
        send_word(MODE_PEEK_FRONT, 32'h0);
        stop_sending();
    endtask

    // single element left at the last slot, popped from the front
    task automatic test_wrap_last_slot();
        write_capacity(6'd3);
        send_word(MODE_PUSH_REAR, 32'h0000_0001);
        send_word(MODE_PUSH_REAR, 32'h0000_0002);
        send_word(MODE_PUSH_REAR, 32'h0000_0003);
        send_word(MODE_PUSH_FRONT, 32'hdead_beef);
        send_word(MODE_POP_FRONT, 32'h0);
        send_word(MODE_POP_FRONT, 32'h0);
        send_word(MODE_POP_FRONT, 32'h0);
        send_word(MODE_POP_FRONT, 32'h0);
        send_word(MODE_PUSH_FRONT, 32'hcafe_f00d);
        send_word(MODE_PEEK_REAR, 32'h0);
        stop_sending();
    endtask

    task automatic test_capacity_extremes();
        write_capacity(6'd0);
        send_word(MODE_PUSH_FRONT, 32'h8000_0001);
        send_word(MODE_PUSH_REAR, 32'h1111_1111);
        send_word(MODE_PEEK_REAR, 32'h0);
        send_word(MODE_POP_REAR, 32'h0);
        stop_sending();
        write_capacity(6'd1);
        send_word(MODE_PUSH_REAR, 32'h7fff_fffe);
        send_word(MODE_PUSH_FRONT, 32'h2222_2222);
        send_word(MODE_POP_FRONT, 32'h0);
        stop_sending();
        write_capacity(6'd63);
        for (int i = 0; i < RING_SLOTS + 1; i++)
            send_word((i % 2) ? MODE_PUSH_FRONT : MODE_PUSH_REAR, pick_word());
        send_word(MODE_PEEK_FRONT, 32'h0);
        for (int i = 0; i < RING_SLOTS + 1; i++)
            send_word((i % 3) ? MODE_POP_REAR : MODE_POP_FRONT, 32'h0);
        stop_sending();
    endtask

    task automatic test_random_phase(input logic [CAP_W-1:0] cap, input int gap,
                                     input int stall, input int count);
        int push_bias;
        int r;
        logic [MODE_W-1:0] op;
        write_capacity(cap);
        gap_pct   = gap;
        stall_pct = stall;
        push_bias = 80;
        for (int i = 0; i < count; i++) begin
            if (i % 32 == 31)
                push_bias = 100 - push_bias;
            r = $urandom_range(99, 0);
            if (r < 3)
                op = $urandom_range(1, 0) ? MODE_SPARE_7 : MODE_SPARE_6;
            else if ($urandom_range(99, 0) < push_bias)
                op = $urandom_range(1, 0) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
            else
                op = MODE_POP_REAR + MODE_W'($urandom_range(3, 0));
            send_word(op, pick_word());
        end
        stop_sending();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        write_capacity(6'd32);
        gap_pct      = 0;
        stall_pct    = 0;
        hold_request = 300;
        for (int i = 0; i < 40; i++)
            send_word((i < 30) ? MODE_PUSH_REAR : MODE_POP_FRONT, pick_word());
        stop_sending();
    endtask

    initial begin
        error_count  = 0;
        words_in     = 0;
        words_out    = 0;
        full_seen    = 0;
        empty_seen   = 0;
        cap_writes   = 0;
        gap_pct      = 0;
        stall_pct    = 0;
        hold_request = 0;
        cap_reg      = CAP_RESET;
        clear_ring();
        for (int i = 0; i < RING_SLOTS; i++)
            ring_mem[i] = '0;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_and_spare_modes();
        test_both_ends();
        test_wrap_last_slot();
        test_capacity_extremes();
        test_backpressure();
        test_random_phase(6'd32, 0, 0, 150);
        test_random_phase(6'd5, 83, 0, 200);
        test_random_phase(6'd63, 0, 83, 200);
        test_random_phase(6'd1, 35, 35, 150);
        test_random_phase(6'd17, 0, 0, 100);
        test_random_phase(CAP_W'($urandom_range(63, 0)), 83, 0, 150);
        test_random_phase(6'd2, 0, 83, 150);
        test_random_phase(CAP_W'($urandom_range(63, 0)), 35, 35, 200);
        test_random_phase(6'd42, 0, 0, 100);
        test_random_phase(6'd0, 83, 83, 100);

        stall_pct = 0;
        drain();
        repeat (5) @(posedge aclk);
        $display("covered %0d requests and %0d results over %0d capacity settings",
                 words_in, words_out, cap_writes);
        $display("refused pushes on full queue %0d, refused reads on empty queue %0d",
                 full_seen, empty_seen);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
